FILE: rtl/core/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg: shared definitions for the matrix keypad scanner
// Field widths, configuration register indexes, reset values and the tick
// descriptor that travels from the debounce front end to the event emitter.
// ----------------------------------------------------------------------------
package kpd_pkg;

    // Default geometry and the limits that size internal fields.
    localparam int ROWS_DEF   = 4;
    localparam int COLS_DEF   = 4;
    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;

    // Port field widths.
    localparam int IN_W       = 4;
    localparam int KEY_W      = 5;
    localparam int NROW_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Debounce counter.
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd3;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_ENABLE     = 1'b0,
        REG_DEBOUNCE_VISITS = 1'b1
    } cfg_reg_t;

    // One scan tick after debounce: which columns changed and their new levels.
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    nrow;
        logic [MAX_COLS-1:0] changed;
        logic [MAX_COLS-1:0] pattern;
    } tick_desc_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

FILE: rtl/core/kpd_if.sv
// ----------------------------------------------------------------------------
// kpd_if: valid/ready channels of the keypad scanner
// Input channel carries the sampled column levels, output channel carries
// one key event (or an empty tick marker) per item.
// ----------------------------------------------------------------------------
interface kpd_in_if;
    logic                      valid;
    logic                      ready;
    logic [kpd_pkg::IN_W-1:0]  column_levels;

    modport source (output valid, output column_levels, input ready);
    modport sink   (input valid, input column_levels, output ready);
endinterface

interface kpd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        event_valid;
    logic [kpd_pkg::KEY_W-1:0]   key_number;
    logic                        released;
    logic [kpd_pkg::NROW_W-1:0]  next_row;
    logic                        last;

    modport source (output valid, output event_valid, output key_number,
                    output released, output next_row, output last, input ready);
    modport sink   (input valid, input event_valid, input key_number,
                    input released, input next_row, input last, output ready);
endinterface

FILE: rtl/core/kpd_front.sv
// ----------------------------------------------------------------------------
// kpd_front: scan tick intake and per-row debounce
// Holds the configuration registers and the row state, accepts one tick per
// cycle while the queue has room, and pushes a tick descriptor while scanning is on.
// ----------------------------------------------------------------------------
module kpd_front #(
    parameter int ROWS = kpd_pkg::ROWS_DEF,
    parameter int COLS = kpd_pkg::COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [kpd_pkg::CFG_DATA_W-1:0]   wr_data,
    kpd_in_if.sink                           in_ch,
    input  kpd_pkg::q_status_t               q_stat,
    output logic                             push,
    output kpd_pkg::tick_desc_t              desc
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [RW-1:0]   LAST_ROW = RW'(ROWS - 1);
    localparam logic [COLS-1:0] COL_MASK = '1;

    logic                          scan_enable_reg;
    logic [kpd_pkg::CNT_W-1:0]     visits_reg;
    logic [RW-1:0]                 row_reg;
    logic [COLS-1:0]               stab_reg [ROWS];
    logic [COLS-1:0]               cand_reg [ROWS];
    logic [kpd_pkg::CNT_W-1:0]     cnt_reg  [ROWS];

    logic                          fire;
    logic [kpd_pkg::MAX_COLS-1:0]  lv_ext;
    logic [COLS-1:0]               pat;
    logic [COLS-1:0]               stab_cur;
    logic                          cand_hit;
    logic                          diff;
    logic                          accept_chg;
    logic [kpd_pkg::CNT_W-1:0]     cnt_base;
    logic [kpd_pkg::CNT_W-1:0]     cnt_inc;
    logic [kpd_pkg::CNT_W-1:0]     cnt_next;
    logic [RW-1:0]                 row_next;

    // Handshake: a tick is taken whenever the queue can hold its descriptor.
    assign in_ch.ready = !q_stat.full;
    assign fire        = in_ch.valid && in_ch.ready;
    assign push        = fire && scan_enable_reg;

    // Debounce decision for the row being visited.
    assign lv_ext   = kpd_pkg::MAX_COLS'(in_ch.column_levels);
    assign pat      = lv_ext[COLS-1:0];
    assign stab_cur = stab_reg[row_reg];

    always_comb
    begin
        cand_hit   = (pat != cand_reg[row_reg]);
        cnt_base   = cand_hit ? '0 : cnt_reg[row_reg];
        diff       = (pat != stab_cur);
        cnt_inc    = (cnt_base == kpd_pkg::CNT_MAX) ? kpd_pkg::CNT_MAX
                                                    : cnt_base + 8'd1;
        accept_chg = diff && (cnt_inc >= visits_reg);
        if (!diff)
        begin
            cnt_next = cnt_base;
        end
        else if (accept_chg)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_inc;
        end
        row_next = (row_reg == LAST_ROW) ? '0 : row_reg + RW'(1);
    end

    // Descriptor handed to the emitter.
    always_comb
    begin
        desc.row     = kpd_pkg::ROW_W'(row_reg);
        desc.nrow    = kpd_pkg::ROW_W'(row_next);
        desc.pattern = kpd_pkg::MAX_COLS'(pat);
        desc.changed = accept_chg ? kpd_pkg::MAX_COLS'(stab_cur ^ pat) : '0;
    end

    // Configuration registers and row state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg <= 1'b0;
            visits_reg      <= kpd_pkg::DEBOUNCE_RST;
            row_reg         <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                stab_reg[r] <= COL_MASK;
                cand_reg[r] <= COL_MASK;
                cnt_reg[r]  <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                case (kpd_pkg::cfg_reg_t'(wr_index))
                    kpd_pkg::REG_SCAN_ENABLE:     scan_enable_reg <= wr_data[0];
                    kpd_pkg::REG_DEBOUNCE_VISITS: visits_reg      <= wr_data;
                    default: ;
                endcase
            end
            if (push)
            begin
                row_reg          <= row_next;
                cand_reg[row_reg] <= pat;
                cnt_reg[row_reg]  <= cnt_next;
                if (accept_chg)
                begin
                    stab_reg[row_reg] <= pat;
                end
            end
        end
    end

endmodule

FILE: rtl/core/kpd_queue.sv
// ----------------------------------------------------------------------------
// kpd_queue: short descriptor queue
// Decouples the debounce front end from the event emitter so that either
// side can stall briefly without holding up the other.
// ----------------------------------------------------------------------------
module kpd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kpd_pkg::tick_desc_t   din,
    input  logic                  pop,
    output kpd_pkg::tick_desc_t   dout,
    output kpd_pkg::q_status_t    stat
);

    localparam int PW = (kpd_pkg::Q_DEPTH > 1) ? $clog2(kpd_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(kpd_pkg::Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(kpd_pkg::Q_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(kpd_pkg::Q_DEPTH);

    kpd_pkg::tick_desc_t   mem_reg [kpd_pkg::Q_DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         rd_ptr_reg;
    logic [CW-1:0]         count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full      = (count_reg == FULL_CNT);
    assign stat.not_empty = (count_reg != '0);
    assign do_push        = push && !stat.full;
    assign do_pop         = pop && stat.not_empty;
    assign dout           = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/kpd_back.sv
// ----------------------------------------------------------------------------
// kpd_back: key event emitter
// Takes one tick descriptor at a time and emits one result per changed
// column, lowest column first, or a single empty result for a quiet tick.
// ----------------------------------------------------------------------------
module kpd_back #(
    parameter int COLS = kpd_pkg::COLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kpd_pkg::q_status_t    q_stat,
    input  kpd_pkg::tick_desc_t   q_dout,
    output logic                  pop,
    kpd_out_if.source             out_ch
);

    logic                            have_reg;
    kpd_pkg::tick_desc_t             cur_reg;
    logic [kpd_pkg::COL_W-1:0]       col;
    logic [kpd_pkg::MAX_COLS-1:0]    low_bit;
    logic [kpd_pkg::MAX_COLS-1:0]    rest;
    logic                            any_evt;
    logic                            beat_last;
    logic [7:0]                      key_full;
    logic                            load;

    // Lowest remaining changed column.
    always_comb
    begin
        col = '0;
        for (int i = kpd_pkg::MAX_COLS - 1; i >= 0; i--)
        begin
            if (cur_reg.changed[i])
            begin
                col = kpd_pkg::COL_W'(i);
            end
        end
        any_evt   = (cur_reg.changed != '0);
        low_bit   = any_evt ? (kpd_pkg::MAX_COLS'(1) << col) : '0;
        rest      = cur_reg.changed & ~low_bit;
        beat_last = (rest == '0);
        key_full  = 8'(cur_reg.row) * 8'(COLS) + 8'(col) + 8'd1;
    end

    // Result fields.
    always_comb
    begin
        out_ch.valid       = have_reg;
        out_ch.event_valid = any_evt;
        out_ch.key_number  = any_evt ? key_full[kpd_pkg::KEY_W-1:0] : '0;
        out_ch.released    = any_evt ? cur_reg.pattern[col] : 1'b0;
        out_ch.next_row    = cur_reg.nrow[kpd_pkg::NROW_W-1:0];
        out_ch.last        = beat_last;
    end

    // Take the next descriptor when idle or when the final result leaves.
    assign load = !have_reg || (out_ch.ready && beat_last);
    assign pop  = load && q_stat.not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (load)
        begin
            have_reg <= q_stat.not_empty;
        end
    end

    // Current descriptor, remaining columns cleared as results leave.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_dout;
        end
        else if (have_reg && out_ch.ready && !beat_last)
        begin
            cur_reg.changed <= rest;
        end
    end

endmodule

FILE: rtl/core/matrix_keypad_scan_debounce.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce: matrix keypad scanner with per-row debounce
// Top level joining the debounce front end, descriptor queue and emitter.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one scan tick per item: the column levels sampled while the
//   reported row was driven low. While scan_enable is 0 ticks are taken and
//   dropped with no effect. out_ch carries the results of each tick: one
//   result per changed column, lowest column first, or one result with
//   event_valid low for a quiet tick. Every result carries next_row, the row
//   to drive for the following scan, and last marks the final one of a tick.
//   The write port (wr_en, wr_index, wr_data) sets scan_enable and
//   debounce_visits; write only while no tick is in flight.
//   A taken tick's descriptor is written into the queue and then loaded into
//   the emitter, which offers its max(1, changed columns) results at one
//   result per cycle while the receiver is ready; the input takes one tick per
//   cycle while the two-entry queue has room.
//   When the receiver stalls, results hold and the queue fills; in_ch.ready
//   then drops until a descriptor moves on.
//   Reset: all rows open, counts cleared, row 0, scanning off, debounce 3.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce #(
    parameter int ROWS = kpd_pkg::ROWS_DEF,
    parameter int COLS = kpd_pkg::COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [kpd_pkg::CFG_DATA_W-1:0]   wr_data,
    kpd_in_if.sink                           in_ch,
    kpd_out_if.source                        out_ch
);

    logic                  push;
    logic                  pop;
    kpd_pkg::tick_desc_t   desc_in;
    kpd_pkg::tick_desc_t   desc_out;
    kpd_pkg::q_status_t    q_stat;

    // Tick intake and debounce.
    kpd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_ch    (in_ch),
        .q_stat   (q_stat),
        .push     (push),
        .desc     (desc_in)
    );

    // Decoupling queue.
    kpd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (desc_in),
        .pop   (pop),
        .dout  (desc_out),
        .stat  (q_stat)
    );

    // Event emission.
    kpd_back #(
        .COLS (COLS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_dout (desc_out),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

FILE: rtl/core/kpd_checker.sv
// ----------------------------------------------------------------------------
// kpd_checker: port-level checks for the keypad scanner
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module kpd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           event_valid,
    input  logic [kpd_pkg::KEY_W-1:0]      key_number,
    input  logic                           released,
    input  logic [kpd_pkg::NROW_W-1:0]     next_row,
    input  logic                           last
);

    // A stalled result stays valid and holds its key, flags and last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_number)
            && $stable(event_valid) && $stable(released) && $stable(last))
    else $error("stalled result changed");

    // A quiet tick is a single empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |-> last && (key_number == '0) && !released)
    else $error("empty result malformed");

    // A key event always names a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid |-> key_number != '0)
    else $error("key event with key number zero");

    // Results of one tick follow back to back and share the next row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && event_valid
            && $stable(next_row))
    else $error("tick results broken up");

endmodule

bind matrix_keypad_scan_debounce kpd_checker u_kpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .event_valid (out_ch.event_valid),
    .key_number  (out_ch.key_number),
    .released    (out_ch.released),
    .next_row    (out_ch.next_row),
    .last        (out_ch.last)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_keypad_scan_debounce
// Scan ticks go in on the input channel and are predicted here, one model tick
// per accepted item. Each key event leaving the output channel is compared with
// the oldest predicted one. Directed tests cover disabled scanning, quiet ticks,
// full-row presses, zero and large debounce, and a bouncing key. A random
// part then scans held key patterns with noise under several debounce settings,
// with random stalls on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS         = 4;
    localparam int COLS         = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int DRAIN_SPINS  = 5000;
    localparam logic [kpd_pkg::IN_W-1:0] COL_MASK   = 4'hF;
    localparam logic [kpd_pkg::IN_W-1:0] ALL_OPEN   = 4'hF;
    localparam logic [kpd_pkg::IN_W-1:0] ALL_CLOSED = 4'h0;

    // One result of a scan tick.
    typedef struct packed {
        logic                       event_valid;
        logic [kpd_pkg::KEY_W-1:0]  key_number;
        logic                       released;
        logic [kpd_pkg::NROW_W-1:0] next_row;
        logic                       last;
    } key_event_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [kpd_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [kpd_pkg::CFG_DATA_W-1:0] wr_data;

    kpd_in_if  in_ch ();
    kpd_out_if out_ch ();

    matrix_keypad_scan_debounce u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Scanner state as the bench expects it.
    logic                           scan_on;
    logic [7:0]                     debounce_setting;
    logic [kpd_pkg::NROW_W-1:0]     scan_row;
    logic [kpd_pkg::IN_W-1:0]       stable_keys    [ROWS];
    logic [kpd_pkg::IN_W-1:0]       candidate_keys [ROWS];
    logic [7:0]                     visit_count    [ROWS];

    // Held key patterns per row for the random stimulus.
    logic [kpd_pkg::IN_W-1:0]       held_keys [ROWS];

    key_event_t expected_events [$];
    int         mismatch_count;
    bit         idling_on;

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void clear_scan_state();
        scan_on          = 1'b0;
        debounce_setting = kpd_pkg::DEBOUNCE_RST;
        scan_row         = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            stable_keys[r]    = COL_MASK;
            candidate_keys[r] = COL_MASK;
            visit_count[r]    = '0;
        end
    endfunction

    function automatic void apply_reg(input kpd_pkg::cfg_reg_t idx,
                                      input logic [kpd_pkg::CFG_DATA_W-1:0] data);
        if (idx == kpd_pkg::REG_SCAN_ENABLE)
            scan_on = data[0];
        else
            debounce_setting = data;
    endfunction

    // Runs one scan tick and queues the key events it must produce.
    function automatic void predict_scan_tick(input logic [kpd_pkg::IN_W-1:0] levels);
        logic [kpd_pkg::NROW_W-1:0] row;
        logic [kpd_pkg::NROW_W-1:0] nrow;
        logic [kpd_pkg::IN_W-1:0]   keys;
        logic [kpd_pkg::IN_W-1:0]   changed;
        key_event_t                 ev;
        int                         n;
        if (!scan_on)
            return;
        row     = scan_row;
        keys    = levels & COL_MASK;
        changed = '0;
        n       = 0;
        nrow    = (row == kpd_pkg::NROW_W'(ROWS - 1)) ? '0 : row + 1'b1;

        // A new pattern restarts the debounce run.
        if (keys != candidate_keys[row])
        begin
            candidate_keys[row] = keys;
            visit_count[row]    = '0;
        end
        if (keys != stable_keys[row])
        begin
            if (visit_count[row] != 8'hFF)
                visit_count[row] = visit_count[row] + 8'd1;
            if (visit_count[row] >= debounce_setting)
            begin
                visit_count[row] = '0;
                changed          = stable_keys[row] ^ keys;
                stable_keys[row] = keys;
            end
        end
        scan_row = nrow;

        // One event per changed column, lowest column first.
        for (int c = 0; c < COLS; c++)
        begin
            if (changed[c])
            begin
                ev.event_valid = 1'b1;
                ev.key_number  = kpd_pkg::KEY_W'(int'(row) * COLS + c + 1);
                ev.released    = keys[c];
                ev.next_row    = nrow;
                ev.last        = 1'b0;
                expected_events.push_back(ev);
                n++;
            end
        end
        if (n == 0)
        begin
            ev = '{event_valid: 1'b0, key_number: '0, released: 1'b0,
                   next_row: nrow, last: 1'b1};
            expected_events.push_back(ev);
        end
        else
        begin
            expected_events[expected_events.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        key_event_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected key event: key_number %0d, event_valid %0d",
                       out_ch.key_number, out_ch.event_valid);
                mismatch_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                compare_field("event_valid", want.event_valid, out_ch.event_valid);
                compare_field("key_number", want.key_number, out_ch.key_number);
                compare_field("released", want.released, out_ch.released);
                compare_field("next_row", want.next_row, out_ch.next_row);
                compare_field("last", want.last, out_ch.last);
            end
        end
    end

    // Receiver: random stall bursts while idling is on.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic drive_tick(input logic [kpd_pkg::IN_W-1:0] levels);
        in_ch.valid         <= 1'b1;
        in_ch.column_levels <= levels;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_scan_tick(levels);
        @(negedge clk);
    endtask

    // Random sender gap between items.
    task automatic sender_pause();
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    // One tick per row, each row getting its nibble of the given map.
    task automatic drive_round(input logic [4*kpd_pkg::IN_W-1:0] row_map);
        repeat (ROWS)
        begin
            drive_tick(row_map[scan_row*kpd_pkg::IN_W +: kpd_pkg::IN_W]);
            sender_pause();
        end
    endtask

    task automatic write_reg(input kpd_pkg::cfg_reg_t idx,
                             input logic [kpd_pkg::CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        apply_reg(idx, data);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Waits for every expected event, then lets the pipeline settle.
    task automatic wait_drained();
        int spins;
        spins = 0;
        in_ch.valid <= 1'b0;
        while (expected_events.size() != 0 && spins < DRAIN_SPINS)
        begin
            @(negedge clk);
            spins++;
        end
        if (expected_events.size() != 0)
        begin
            $error("%0d expected key events never arrived", expected_events.size());
            mismatch_count++;
            expected_events.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random held patterns with occasional changes and bounce noise.
    task automatic scan_random_keys(input int ticks);
        logic [kpd_pkg::IN_W-1:0] levels;
        repeat (ticks)
        begin
            if ($urandom_range(0, 11) == 0)
                held_keys[scan_row] = kpd_pkg::IN_W'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0)
                levels = kpd_pkg::IN_W'($urandom);
            else
                levels = held_keys[scan_row];
            drive_tick(levels);
            sender_pause();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ticks while scanning is off are dropped and change nothing.
    task automatic test_disabled_scan();
        drive_tick(ALL_CLOSED);
        drive_tick(ALL_OPEN);
        drive_tick(4'h5);
        wait_drained();
        // Only bit 0 of the enable register counts.
        write_reg(kpd_pkg::REG_SCAN_ENABLE, 8'hFE);
        drive_tick(4'hA);
        wait_drained();
    endtask

    // Quiet ticks, a full row pressed and released, single keys.
    task automatic test_quiet_and_full_row();
        write_reg(kpd_pkg::REG_DEBOUNCE_VISITS, 8'd1);
        write_reg(kpd_pkg::REG_SCAN_ENABLE, 8'h01);
        drive_round({ALL_OPEN, 4'hE, ALL_CLOSED, ALL_OPEN});
        drive_round({ALL_OPEN, ALL_OPEN, ALL_OPEN, ALL_OPEN});
        wait_drained();
    endtask

    // A debounce setting of zero accepts a change on the first visit.
    task automatic test_debounce_zero();
        write_reg(kpd_pkg::REG_DEBOUNCE_VISITS, 8'd0);
        drive_tick(4'h6);
        drive_tick(4'h9);
        drive_tick(ALL_OPEN);
        drive_tick(ALL_OPEN);
        drive_tick(ALL_OPEN);
        wait_drained();
    endtask

    // A bounce back to another pattern restarts the visit count.
    task automatic test_bounce_restart();
        write_reg(kpd_pkg::REG_DEBOUNCE_VISITS, 8'd3);
        drive_round({ALL_OPEN, ALL_OPEN, 4'hF, 4'h7});
        drive_round({ALL_OPEN, 4'h3, ALL_OPEN, 4'hB});
        drive_round({ALL_OPEN, 4'h3, ALL_OPEN, 4'hB});
        drive_round({ALL_OPEN, 4'h3, ALL_OPEN, 4'hB});
        wait_drained();
    endtask

    // Large debounce settings: nothing lands under the largest one, then the
    // visits already counted carry over to a lower setting, where the changes
    // land on its last visit only.
    task automatic test_max_debounce();
        logic [4*kpd_pkg::IN_W-1:0] row_map;
        write_reg(kpd_pkg::REG_DEBOUNCE_VISITS, 8'hFF);
        row_map = 16'($urandom);
        repeat (16)
            drive_round(row_map);
        wait_drained();
        write_reg(kpd_pkg::REG_DEBOUNCE_VISITS, 8'd40);
        repeat (24)
            drive_round(row_map);
        wait_drained();
    endtask

    // Random scanning under several settings; the last phase runs without stalls.
    task automatic test_random_scanning();
        logic [kpd_pkg::CFG_DATA_W-1:0] setting [6];
        setting = '{8'd1, 8'd2, kpd_pkg::CFG_DATA_W'($urandom_range(1, 8)), 8'd4,
                    8'd3, 8'd1};
        for (int r = 0; r < ROWS; r++)
            held_keys[r] = stable_keys[r];
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                idling_on = 1'b0;
            write_reg(kpd_pkg::REG_DEBOUNCE_VISITS, setting[ph]);
            scan_random_keys(50);
            wait_drained();
            // Occasionally pause scanning, feed noise, and resume.
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(kpd_pkg::REG_SCAN_ENABLE, {7'($urandom), 1'b0});
                repeat ($urandom_range(1, 6))
                    drive_tick(kpd_pkg::IN_W'($urandom));
                wait_drained();
                write_reg(kpd_pkg::REG_SCAN_ENABLE, {7'($urandom), 1'b1});
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = kpd_pkg::REG_SCAN_ENABLE;
        wr_data             = '0;
        in_ch.valid         = 1'b0;
        in_ch.column_levels = ALL_OPEN;
        mismatch_count      = 0;
        idling_on           = 1'b1;
        clear_scan_state();

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_disabled_scan();
        test_quiet_and_full_row();
        test_debounce_zero();
        test_bounce_restart();
        test_max_debounce();
        test_random_scanning();

        wait_drained();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit.
    initial
    begin
        #(20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
